/* rtl/core/rtp_hevc_header_parser_unit_defines.svh */
// Assertion macros shared by the RTP HEVC header parser checker
`ifndef RTP_HEVC_HEADER_PARSER_UNIT_DEFINES_SVH
`define RTP_HEVC_HEADER_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define RHHP_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RHHP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/rhhp_pkg.sv */
// Types and constants of the RTP HEVC header parser
package rhhp_pkg;

	localparam int MAX_PACKET_BYTES = 4096;
	// byte counter holds the maximum itself
	localparam int IDX_W = $clog2(MAX_PACKET_BYTES + 1);
	// payload start: 72 + 4 + 4 * 65535 needs 19 bits, never wraps
	localparam int PSTART_W = 19;
	localparam int LEN_W = 13;
	localparam int STATUS_W = 4;
	localparam int PT_W = 7;

	localparam int FIXED_HDR_BYTES = 12;
	localparam int EXT_HDR_BYTES = 4;
	localparam logic [PT_W-1:0] PT_RESET = 7'd96;
	localparam logic [1:0] RTP_VERSION = 2'd2;
	localparam logic [5:0] NAL_FU = 6'd49;
	localparam logic [7:0] NAL_IRAP_FIRST = 8'd16;
	localparam logic [7:0] NAL_IRAP_LAST = 8'd21;
	localparam logic [7:0] NAL_NONE = 8'hff;

	localparam logic [STATUS_W-1:0] ST_OK = 4'd0;
	localparam logic [STATUS_W-1:0] ST_SHORT_HDR = 4'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_VERSION = 4'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_PT = 4'd3;
	localparam logic [STATUS_W-1:0] ST_SHORT_CSRC = 4'd4;
	localparam logic [STATUS_W-1:0] ST_SHORT_EXT_HDR = 4'd5;
	localparam logic [STATUS_W-1:0] ST_SHORT_EXT = 4'd6;
	localparam logic [STATUS_W-1:0] ST_BAD_PADDING = 4'd7;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 4'd8;
	localparam logic [STATUS_W-1:0] ST_TOO_LONG = 4'd9;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} pkt_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                marker;
		logic [15:0]         sequence_number;
		logic [31:0]         rtp_timestamp;
		logic [31:0]         source_id;
		logic                ext_present;
		logic [15:0]         ext_profile;
		logic [LEN_W-1:0]    ext_length;
		logic [LEN_W-1:0]    pay_offset;
		logic [LEN_W-1:0]    pay_length;
		logic [7:0]          nal_unit_type;
		logic                is_irap;
	} desc_t;

endpackage

/* rtl/core/rtp_hevc_header_parser_unit.sv */
// A packet's descriptor is registered when its last byte leaves the input register.
// Throughput: one byte per cycle while the input side does not stall; an input register and a descriptor register
// bound the single pass of compares and captures made for each byte.
// The input side stalls only when a last byte meets a descriptor still waiting.
// Reset (arst_n low, asynchronous) empties both registers, clears the packet
// state and sets the expected payload type to 96.
module rtp_hevc_header_parser_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pkt_valid,
	output logic                         pkt_stall,
	input  rhhp_pkg::pkt_t               pkt,
	output logic                         desc_valid,
	input  logic                         desc_stall,
	output rhhp_pkg::desc_t              desc,
	input  logic                         cfg_wr_en,
	input  logic [rhhp_pkg::PT_W-1:0]    cfg_wr_data
);
	import rhhp_pkg::*;

	// input register
	logic          pkt_valid_s1;
	pkt_t          pkt_s1;
	logic          go;

	// configuration
	logic [PT_W-1:0] pt_q;

	// packet state
	logic [IDX_W-1:0]    idx_q;
	logic                too_long_q;
	logic [7:0]          fhb_q;
	logic [7:0]          shb_q;
	logic [15:0]         seq_q;
	logic [31:0]         ts_q;
	logic [31:0]         src_q;
	logic [15:0]         prof_q;
	logic [15:0]         words_q;
	logic [PSTART_W-1:0] pstart_q;
	logic [7:0]          pfirst_q;
	logic [7:0]          pthird_q;

	// next state
	logic [IDX_W-1:0]    idx_n;
	logic                too_long_n;
	logic [7:0]          fhb_n;
	logic [7:0]          shb_n;
	logic [15:0]         seq_n;
	logic [31:0]         ts_n;
	logic [31:0]         src_n;
	logic [15:0]         prof_n;
	logic [15:0]         words_n;
	logic [PSTART_W-1:0] pstart_n;
	logic [7:0]          pfirst_n;
	logic [7:0]          pthird_n;

	logic [7:0]          b;
	logic                capt;
	logic [PSTART_W-1:0] i_w;
	logic [6:0]          hdr_q;
	logic [6:0]          hdr_b;
	logic [PSTART_W-1:0] rel;
	logic                ext_zone;
	logic [15:0]         words_full;

	// end of packet
	logic [6:0]          hdr_n;
	logic                ext_n;
	logic [PSTART_W-1:0] size_w;
	logic [PSTART_W-1:0] offset;
	logic [PSTART_W-1:0] avail;
	logic [PSTART_W-1:0] len;
	logic [STATUS_W-1:0] status;
	logic [5:0]          nal_raw;
	logic [7:0]          nal;
	desc_t               result;

	logic                desc_valid_q;
	desc_t               desc_q;

	// advance the input register unless a last byte would overwrite a waiting descriptor
	assign go        = pkt_valid_s1 && (!pkt_s1.last_byte || !desc_valid_q || !desc_stall);
	assign pkt_stall = pkt_valid_s1 && !go;

	assign desc_valid = desc_valid_q;
	assign desc       = desc_q;

	// capture of one byte
	always_comb begin
		b          = pkt_s1.data_byte;
		capt       = (idx_q < IDX_W'(MAX_PACKET_BYTES));
		i_w        = PSTART_W'(idx_q);
		hdr_q      = 7'(FIXED_HDR_BYTES) + {1'b0, fhb_q[3:0], 2'b00};
		hdr_b      = 7'(FIXED_HDR_BYTES) + {1'b0, b[3:0], 2'b00};
		rel        = i_w - PSTART_W'(hdr_q);
		ext_zone   = fhb_q[4] && (i_w >= PSTART_W'(hdr_q)) && (idx_q != '0);
		words_full = {words_q[15:8], b};

		idx_n      = idx_q;
		too_long_n = too_long_q;
		fhb_n      = fhb_q;
		shb_n      = shb_q;
		seq_n      = seq_q;
		ts_n       = ts_q;
		src_n      = src_q;
		prof_n     = prof_q;
		words_n    = words_q;
		pstart_n   = pstart_q;
		pfirst_n   = pfirst_q;
		pthird_n   = pthird_q;

		if (!capt) begin
			too_long_n = 1'b1;
		end else begin
			idx_n = idx_q + IDX_W'(1);
			if (idx_q == '0) begin
				fhb_n    = b;
				pstart_n = PSTART_W'(hdr_b);
			end else begin
				if (i_w == PSTART_W'(1)) begin
					shb_n = b;
				end else if (i_w < PSTART_W'(4)) begin
					seq_n = {seq_q[7:0], b};
				end else if (i_w < PSTART_W'(8)) begin
					ts_n = {ts_q[23:0], b};
				end else if (i_w < PSTART_W'(FIXED_HDR_BYTES)) begin
					src_n = {src_q[23:0], b};
				end
				// extension header: profile word, then length in words
				if (ext_zone) begin
					if (rel < PSTART_W'(2)) begin
						prof_n = {prof_q[7:0], b};
					end else if (rel == PSTART_W'(2)) begin
						words_n = {b, 8'h00};
					end else if (rel == PSTART_W'(3)) begin
						words_n  = words_full;
						pstart_n = PSTART_W'(hdr_q) + PSTART_W'(EXT_HDR_BYTES)
							+ PSTART_W'({words_full, 2'b00});
					end
				end
				// hold the first and third payload bytes for the NAL header
				if (i_w >= PSTART_W'(FIXED_HDR_BYTES)) begin
					if (i_w == pstart_q) begin
						pfirst_n = b;
					end
					if (i_w == pstart_q + PSTART_W'(2)) begin
						pthird_n = b;
					end
				end
			end
		end
	end

	// checks and descriptor at the last byte
	always_comb begin
		hdr_n  = 7'(FIXED_HDR_BYTES) + {1'b0, fhb_n[3:0], 2'b00};
		ext_n  = fhb_n[4];
		size_w = PSTART_W'(idx_n);
		offset = ext_n ? pstart_n : PSTART_W'(hdr_n);
		avail  = size_w - offset;
		len    = avail;
		status = ST_OK;

		if (too_long_n) begin
			status = ST_TOO_LONG;
		end else if (size_w < PSTART_W'(FIXED_HDR_BYTES)) begin
			status = ST_SHORT_HDR;
		end else if (fhb_n[7:6] != RTP_VERSION) begin
			status = ST_BAD_VERSION;
		end else if (shb_n[6:0] != pt_q) begin
			status = ST_BAD_PT;
		end else if (PSTART_W'(hdr_n) > size_w) begin
			status = ST_SHORT_CSRC;
		end else if (ext_n && (PSTART_W'(hdr_n) + PSTART_W'(EXT_HDR_BYTES) > size_w)) begin
			status = ST_SHORT_EXT_HDR;
		end else if (ext_n && (offset > size_w)) begin
			status = ST_SHORT_EXT;
		end else begin
			// padding count is the final byte itself
			if (fhb_n[5]) begin
				if ((b == 8'h00) || (PSTART_W'(b) > avail)) begin
					status = ST_BAD_PADDING;
				end else begin
					len = avail - PSTART_W'(b);
				end
			end
			if ((status == ST_OK) && (len == '0)) begin
				status = ST_EMPTY;
			end
		end

		// NAL type; a fragmentation unit takes it from the FU header with start bit set
		nal_raw = pfirst_n[6:1];
		nal     = NAL_NONE;
		if (len >= PSTART_W'(2)) begin
			if (nal_raw == NAL_FU) begin
				if ((len >= PSTART_W'(3)) && pthird_n[7]) begin
					nal = {2'b00, pthird_n[5:0]};
				end
			end else begin
				nal = {2'b00, nal_raw};
			end
		end

		result               = '0;
		result.status        = status;
		result.nal_unit_type = NAL_NONE;
		if (status == ST_OK) begin
			result.marker          = shb_n[7];
			result.sequence_number = seq_n;
			result.rtp_timestamp   = ts_n;
			result.source_id       = src_n;
			result.ext_present     = ext_n;
			result.ext_profile     = ext_n ? prof_n : 16'h0000;
			result.ext_length      = ext_n ? LEN_W'({words_n, 2'b00}) : '0;
			result.pay_offset      = offset[LEN_W-1:0];
			result.pay_length      = len[LEN_W-1:0];
			result.nal_unit_type   = nal;
			result.is_irap         = (nal >= NAL_IRAP_FIRST) && (nal <= NAL_IRAP_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_valid_s1 <= 1'b0;
			desc_valid_q <= 1'b0;
			pt_q         <= PT_RESET;
			idx_q        <= '0;
			too_long_q   <= 1'b0;
			fhb_q        <= '0;
			shb_q        <= '0;
			seq_q        <= '0;
			ts_q         <= '0;
			src_q        <= '0;
			prof_q       <= '0;
			words_q      <= '0;
			pstart_q     <= PSTART_W'(FIXED_HDR_BYTES);
			pfirst_q     <= '0;
			pthird_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				pt_q <= cfg_wr_data;
			end
			if (!pkt_stall) begin
				pkt_valid_s1 <= pkt_valid;
			end
			// drop the descriptor once transferred, load a new one on a last byte
			if (go && pkt_s1.last_byte) begin
				desc_valid_q <= 1'b1;
			end else if (!desc_stall) begin
				desc_valid_q <= 1'b0;
			end
			if (go) begin
				if (pkt_s1.last_byte) begin
					idx_q      <= '0;
					too_long_q <= 1'b0;
					fhb_q      <= '0;
					shb_q      <= '0;
					seq_q      <= '0;
					ts_q       <= '0;
					src_q      <= '0;
					prof_q     <= '0;
					words_q    <= '0;
					pstart_q   <= PSTART_W'(FIXED_HDR_BYTES);
					pfirst_q   <= '0;
					pthird_q   <= '0;
				end else begin
					idx_q      <= idx_n;
					too_long_q <= too_long_n;
					fhb_q      <= fhb_n;
					shb_q      <= shb_n;
					seq_q      <= seq_n;
					ts_q       <= ts_n;
					src_q      <= src_n;
					prof_q     <= prof_n;
					words_q    <= words_n;
					pstart_q   <= pstart_n;
					pfirst_q   <= pfirst_n;
					pthird_q   <= pthird_n;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pkt_valid && !pkt_stall) begin
			pkt_s1 <= pkt;
		end
		if (go && pkt_s1.last_byte) begin
			desc_q <= result;
		end
	end

endmodule

/* rtl/core/rhhp_checker.sv */
// Port checker for the RTP HEVC header parser, bound to the top level
`include "rtp_hevc_header_parser_unit_defines.svh"

module rhhp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         desc_valid,
	input logic                         desc_stall,
	input rhhp_pkg::desc_t              desc
);
	import rhhp_pkg::*;

	`RHHP_ASSERT_NEXT(a_desc_hold, clk, arst_n, desc_valid && desc_stall,
		desc_valid && $stable(desc), "descriptor changed while stalled")
	`RHHP_ASSERT_IMPLY(a_fail_clean, clk, arst_n, desc_valid && (desc.status != ST_OK),
		(desc.nal_unit_type == NAL_NONE) && !desc.is_irap && (desc.pay_length == '0),
		"failed packet carries fields")
	`RHHP_ASSERT_IMPLY(a_irap_range, clk, arst_n, desc_valid && desc.is_irap,
		(desc.nal_unit_type >= NAL_IRAP_FIRST) && (desc.nal_unit_type <= NAL_IRAP_LAST),
		"IRAP flag outside its types")
	`RHHP_ASSERT_IMPLY(a_no_ext, clk, arst_n, desc_valid && !desc.ext_present,
		(desc.ext_profile == '0) && (desc.ext_length == '0),
		"extension fields without extension")
	`RHHP_ASSERT_IMPLY(a_ok_payload, clk, arst_n, desc_valid && (desc.status == ST_OK),
		(desc.pay_length != '0) && (desc.pay_offset >= LEN_W'(FIXED_HDR_BYTES)),
		"good packet without payload")

endmodule

bind rtp_hevc_header_parser_unit rhhp_checker u_rhhp_checker (.*);
